// ===== hdl/jplg_pkg.sv =====
// Shared types and constants of the joint position limit guard.
package jplg_pkg;

  localparam int MAX_AXES = 4;
  localparam int FIELD_WIDTH = 16;
  localparam int CFG_WIDTH = 64;
  localparam int ENABLE_WIDTH = 8;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam int DEFAULT_AXES = 4;
  localparam int DEFAULT_POS_WIDTH = 16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LOWER_BOUNDS  = 2'd0,
    REG_UPPER_BOUNDS  = 2'd1,
    REG_STEP_BOUNDS   = 2'd2,
    REG_CHECK_ENABLES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic fault;
    logic below;
    logic above;
    logic jump;
  } lane_flags_t;

endpackage

// ===== hdl/jplg_lane.sv =====
// Per-axis check lane: bound compare, step compare and reference position register.
module jplg_lane #(
  parameter int POS_WIDTH = jplg_pkg::DEFAULT_POS_WIDTH
) (
  input  logic                               clk,
  input  logic [jplg_pkg::FIELD_WIDTH-1:0]   pos_raw,
  input  logic                               nonfinite,
  input  logic [jplg_pkg::FIELD_WIDTH-1:0]   lower,
  input  logic [jplg_pkg::FIELD_WIDTH-1:0]   upper,
  input  logic [jplg_pkg::FIELD_WIDTH-1:0]   step,
  input  logic                               bound_en,
  input  logic                               step_en,
  input  logic                               ref_valid,
  input  logic                               update,
  output jplg_pkg::lane_flags_t              flags,
  output logic [jplg_pkg::FIELD_WIDTH-1:0]   pos_out
);
  import jplg_pkg::*;

  logic signed [POS_WIDTH-1:0] pos;
  logic signed [POS_WIDTH-1:0] lo;
  logic signed [POS_WIDTH-1:0] hi;
  logic signed [POS_WIDTH-1:0] ref_pos;
  logic signed [POS_WIDTH:0]   diff;
  logic [POS_WIDTH:0]          mag;
  logic [FIELD_WIDTH:0]        mag_ext;
  logic                        is_below;

  assign pos = $signed(pos_raw[POS_WIDTH-1:0]);
  assign lo  = $signed(lower[POS_WIDTH-1:0]);
  assign hi  = $signed(upper[POS_WIDTH-1:0]);

  assign diff    = (POS_WIDTH+1)'(pos) - (POS_WIDTH+1)'(ref_pos);
  assign mag     = diff[POS_WIDTH] ? (POS_WIDTH+1)'(-diff) : diff;
  assign mag_ext = (FIELD_WIDTH+1)'(mag);

  assign is_below    = pos < lo;
  assign flags.fault = nonfinite;
  assign flags.below = bound_en && !nonfinite && is_below;
  assign flags.above = bound_en && !nonfinite && !is_below && (pos > hi);
  assign flags.jump  = step_en && ref_valid && !nonfinite && (mag_ext > {1'b0, step});
  assign pos_out     = FIELD_WIDTH'(pos);

  always_ff @(posedge clk) begin
    if (update) begin
      ref_pos <= pos;
    end
  end

endmodule

// ===== hdl/jplg_merge.sv =====
// Merging stage: combines lane flags, keeps the guard state and registers the result.
module jplg_merge (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 in_fire,
  input  jplg_pkg::lane_flags_t [jplg_pkg::MAX_AXES-1:0]       flags,
  input  logic [jplg_pkg::MAX_AXES-1:0][jplg_pkg::FIELD_WIDTH-1:0] pos,
  input  logic                                                 out_ready,
  output logic                                                 out_valid,
  output logic                                                 update,
  output logic                                                 ref_valid,
  output logic                                                 accepted,
  output logic [jplg_pkg::MAX_AXES-1:0][jplg_pkg::FIELD_WIDTH-1:0] passed,
  output logic [jplg_pkg::MAX_AXES-1:0]                        below_mask,
  output logic [jplg_pkg::MAX_AXES-1:0]                        above_mask,
  output logic [jplg_pkg::MAX_AXES-1:0]                        jump_mask,
  output logic                                                 recovered
);
  import jplg_pkg::*;

  logic [MAX_AXES-1:0] fault_bits;
  logic [MAX_AXES-1:0] below_bits;
  logic [MAX_AXES-1:0] above_bits;
  logic [MAX_AXES-1:0] jump_bits;
  logic                ok;
  logic                previous_ok;

  always_comb begin
    for (int k = 0; k < MAX_AXES; k++) begin
      fault_bits[k] = flags[k].fault;
      below_bits[k] = flags[k].below;
      above_bits[k] = flags[k].above;
      jump_bits[k]  = flags[k].jump;
    end
  end

  assign ok     = !(|fault_bits || |below_bits || |above_bits || |jump_bits);
  assign update = in_fire && ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      ref_valid   <= 1'b0;
      previous_ok <= 1'b1;
    end else begin
      out_valid <= in_fire || (out_valid && !out_ready);
      if (in_fire) begin
        previous_ok <= ok;
        if (ok) begin
          ref_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      accepted   <= ok;
      passed     <= ok ? pos : '0;
      below_mask <= below_bits;
      above_mask <= above_bits;
      jump_mask  <= jump_bits;
      recovered  <= ok && !previous_ok;
    end
  end

  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> below_mask == '0 && above_mask == '0 && jump_mask == '0)
    else $error("Accepted result carries fault flags.");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> passed == '0 && !recovered)
    else $error("Rejected result forwards positions or recovery.");

  a_ref_set: assert property (@(posedge clk) disable iff (rst)
    update |=> ref_valid)
    else $error("Reference not marked valid after an accepted vector.");

  a_ref_hold: assert property (@(posedge clk) disable iff (rst)
    !update |=> $stable(ref_valid))
    else $error("Reference validity changed without an accepted vector.");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !in_fire |=> out_valid && $stable(accepted))
    else $error("Stalled result lost.");

endmodule

// ===== hdl/joint_position_limit_guard_unit.sv =====
// Top level of the joint position limit guard: configuration registers, lanes and merge.
// Latency: the result of an input transfer is valid on the cycle after that transfer.
// Throughput: one vector per cycle while the result side is ready; all axis lanes compare in parallel and
// the merge stage output register holds the result until its transfer.
// Reset clears the configuration registers, the reference-valid flag and the output
// valid, and sets the previous-ok flag; reference positions are written before use.
module joint_position_limit_guard_unit #(
  parameter int AXES      = jplg_pkg::DEFAULT_AXES,
  parameter int POS_WIDTH = jplg_pkg::DEFAULT_POS_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [jplg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [jplg_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_a,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_b,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_c,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_d,
  input  logic [jplg_pkg::MAX_AXES-1:0]        nonfinite_mask,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 accepted,
  output logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_a,
  output logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_b,
  output logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_c,
  output logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_d,
  output logic [jplg_pkg::MAX_AXES-1:0]        below_mask,
  output logic [jplg_pkg::MAX_AXES-1:0]        above_mask,
  output logic [jplg_pkg::MAX_AXES-1:0]        jump_mask,
  output logic                                 recovered
);
  import jplg_pkg::*;

  logic [CFG_WIDTH-1:0]    lower_bounds;
  logic [CFG_WIDTH-1:0]    upper_bounds;
  logic [CFG_WIDTH-1:0]    step_bounds;
  logic [ENABLE_WIDTH-1:0] check_enables;

  logic                                      in_fire;
  logic                                      update;
  logic                                      ref_valid;
  logic [MAX_AXES-1:0][FIELD_WIDTH-1:0]      pos_in;
  logic [MAX_AXES-1:0][FIELD_WIDTH-1:0]      pos_lane;
  lane_flags_t [MAX_AXES-1:0]                flags;
  logic [MAX_AXES-1:0][FIELD_WIDTH-1:0]      passed;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bounds  <= '0;
      upper_bounds  <= '0;
      step_bounds   <= '0;
      check_enables <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOWER_BOUNDS:  lower_bounds  <= cfg_data;
        REG_UPPER_BOUNDS:  upper_bounds  <= cfg_data;
        REG_STEP_BOUNDS:   step_bounds   <= cfg_data;
        REG_CHECK_ENABLES: check_enables <= cfg_data[ENABLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign pos_in[0] = position_a;
  assign pos_in[1] = position_b;
  assign pos_in[2] = position_c;
  assign pos_in[3] = position_d;

  for (genvar k = 0; k < MAX_AXES; k++) begin : g_lane
    if (k < AXES) begin : g_active
      jplg_lane #(
        .POS_WIDTH(POS_WIDTH)
      ) u_lane (
        .clk      (clk),
        .pos_raw  (pos_in[k]),
        .nonfinite(nonfinite_mask[k]),
        .lower    (lower_bounds[FIELD_WIDTH*k +: FIELD_WIDTH]),
        .upper    (upper_bounds[FIELD_WIDTH*k +: FIELD_WIDTH]),
        .step     (step_bounds[FIELD_WIDTH*k +: FIELD_WIDTH]),
        .bound_en (check_enables[k]),
        .step_en  (check_enables[MAX_AXES + k]),
        .ref_valid(ref_valid),
        .update   (update),
        .flags    (flags[k]),
        .pos_out  (pos_lane[k])
      );
    end else begin : g_unused
      assign flags[k]    = '0;
      assign pos_lane[k] = '0;
    end
  end

  jplg_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .flags     (flags),
    .pos       (pos_lane),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .update    (update),
    .ref_valid (ref_valid),
    .accepted  (accepted),
    .passed    (passed),
    .below_mask(below_mask),
    .above_mask(above_mask),
    .jump_mask (jump_mask),
    .recovered (recovered)
  );

  assign passed_a = passed[0];
  assign passed_b = passed[1];
  assign passed_c = passed[2];
  assign passed_d = passed[3];

endmodule

// ===== bench/jplg_checker.sv =====
// Checker for the joint position limit guard: predicts every result and compares it on transfer.
module jplg_checker #(
  parameter int AXES      = jplg_pkg::DEFAULT_AXES,
  parameter int POS_WIDTH = jplg_pkg::DEFAULT_POS_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [jplg_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [jplg_pkg::CFG_WIDTH-1:0]          cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_a,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_b,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_c,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] position_d,
  input  logic [jplg_pkg::MAX_AXES-1:0]           nonfinite_mask,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic                                    accepted,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_a,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_b,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_c,
  input  logic signed [jplg_pkg::FIELD_WIDTH-1:0] passed_d,
  input  logic [jplg_pkg::MAX_AXES-1:0]           below_mask,
  input  logic [jplg_pkg::MAX_AXES-1:0]           above_mask,
  input  logic [jplg_pkg::MAX_AXES-1:0]           jump_mask,
  input  logic                                    recovered,
  output int                                      mismatches,
  output int                                      outstanding,
  output int                                      verdicts_seen,
  output int                                      stops_seen,
  output int                                      recoveries_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import jplg_pkg::*;

  localparam int SHIFT = FIELD_WIDTH - POS_WIDTH;

  typedef struct packed {
    logic                                   accepted;
    logic [MAX_AXES-1:0][FIELD_WIDTH-1:0]   passed;
    logic [MAX_AXES-1:0]                    below;
    logic [MAX_AXES-1:0]                    above;
    logic [MAX_AXES-1:0]                    jump;
    logic                                   recovered;
  } guard_verdict_t;

  logic [CFG_WIDTH-1:0]          lo_bounds;
  logic [CFG_WIDTH-1:0]          hi_bounds;
  logic [CFG_WIDTH-1:0]          step_limits;
  logic [ENABLE_WIDTH-1:0]       enables;
  logic signed [FIELD_WIDTH-1:0] ref_pos [MAX_AXES];
  logic                          have_ref;
  logic                          last_ok;
  guard_verdict_t                awaited [$];

  function automatic logic signed [FIELD_WIDTH-1:0] narrow(input logic [FIELD_WIDTH-1:0] raw);
    logic signed [FIELD_WIDTH-1:0] t;
    t = raw << SHIFT;
    return t >>> SHIFT;
  endfunction

  task automatic judge_vector(input logic [MAX_AXES-1:0][FIELD_WIDTH-1:0] raw,
                              input logic [MAX_AXES-1:0] bad, output guard_verdict_t v);
    logic signed [FIELD_WIDTH-1:0] pos [MAX_AXES];
    int  gap;
    logic ok;
    v = '0;
    ok = 1'b1;
    for (int k = 0; k < MAX_AXES; k++) pos[k] = '0;
    for (int k = 0; k < AXES; k++) begin
      pos[k] = narrow(raw[k]);
      if (bad[k]) begin
        ok = 1'b0;
      end else begin
        if (enables[k]) begin
          if (pos[k] < narrow(lo_bounds[16*k +: 16])) v.below[k] = 1'b1;
          else if (pos[k] > narrow(hi_bounds[16*k +: 16])) v.above[k] = 1'b1;
        end
        if (have_ref && enables[MAX_AXES+k]) begin
          gap = int'(pos[k]) - int'(ref_pos[k]);
          if (gap < 0) gap = -gap;
          if (gap > int'(step_limits[16*k +: 16])) v.jump[k] = 1'b1;
        end
      end
    end
    if ((v.below | v.above | v.jump) != '0) ok = 1'b0;
    v.accepted = ok;
    v.recovered = ok && !last_ok;
    if (ok) begin
      for (int k = 0; k < MAX_AXES; k++) begin
        v.passed[k] = pos[k];
        ref_pos[k] = pos[k];
      end
      have_ref = 1'b1;
    end
    last_ok = ok;
  endtask

  task automatic compare_field(input string what, input logic [FIELD_WIDTH-1:0] want,
                               input logic [FIELD_WIDTH-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%t: %s mismatch in result %0d: expected %h, got %h",
                 $realtime, what, verdicts_seen, want, got);
    end
  endtask

  always @(posedge clk) begin
    guard_verdict_t want;
    guard_verdict_t got;
    if (rst) begin
      lo_bounds = '0;
      hi_bounds = '0;
      step_limits = '0;
      enables = '0;
      have_ref = 1'b0;
      last_ok = 1'b1;
      awaited.delete();
      mismatches = 0;
      verdicts_seen = 0;
      stops_seen = 0;
      recoveries_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.accepted = accepted;
        got.passed = {passed_d, passed_c, passed_b, passed_a};
        got.below = below_mask;
        got.above = above_mask;
        got.jump = jump_mask;
        got.recovered = recovered;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result transfer with no vector outstanding", $realtime);
        end else begin
          want = awaited.pop_front();
          compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
          compare_field("passed_a", want.passed[0], got.passed[0]);
          compare_field("passed_b", want.passed[1], got.passed[1]);
          compare_field("passed_c", want.passed[2], got.passed[2]);
          compare_field("passed_d", want.passed[3], got.passed[3]);
          compare_field("below_mask", 16'(want.below), 16'(got.below));
          compare_field("above_mask", 16'(want.above), 16'(got.above));
          compare_field("jump_mask", 16'(want.jump), 16'(got.jump));
          compare_field("recovered", 16'(want.recovered), 16'(got.recovered));
          verdicts_seen++;
          if (!want.accepted) stops_seen++;
          if (want.recovered) recoveries_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LOWER_BOUNDS:  lo_bounds = cfg_data;
          REG_UPPER_BOUNDS:  hi_bounds = cfg_data;
          REG_STEP_BOUNDS:   step_limits = cfg_data;
          REG_CHECK_ENABLES: enables = cfg_data[ENABLE_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        judge_vector({position_d, position_c, position_b, position_a}, nonfinite_mask, want);
        awaited.push_back(want);
      end
    end
    outstanding = awaited.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the joint position limit guard bench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jplg_pkg::*;

  localparam int LONG_HOLD = 60;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]     cfg_index = REG_LOWER_BOUNDS;
  logic [CFG_WIDTH-1:0]           cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [FIELD_WIDTH-1:0]  position_a = '0;
  logic signed [FIELD_WIDTH-1:0]  position_b = '0;
  logic signed [FIELD_WIDTH-1:0]  position_c = '0;
  logic signed [FIELD_WIDTH-1:0]  position_d = '0;
  logic [MAX_AXES-1:0]            nonfinite_mask = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  logic                           accepted;
  logic signed [FIELD_WIDTH-1:0]  passed_a;
  logic signed [FIELD_WIDTH-1:0]  passed_b;
  logic signed [FIELD_WIDTH-1:0]  passed_c;
  logic signed [FIELD_WIDTH-1:0]  passed_d;
  logic [MAX_AXES-1:0]            below_mask;
  logic [MAX_AXES-1:0]            above_mask;
  logic [MAX_AXES-1:0]            jump_mask;
  logic                           recovered;

  int mismatches;
  int outstanding;
  int verdicts_seen;
  int stops_seen;
  int recoveries_seen;

  logic                  in_taken = 1'b0;
  bit                    calm = 1'b0;
  bit                    squeeze_req = 1'b0;
  bit                    squeeze_done = 1'b0;
  int                    settings_used = 0;
  int                    lo_lane [MAX_AXES];
  int                    hi_lane [MAX_AXES];
  int                    step_lane [MAX_AXES];
  int                    anchor [MAX_AXES];
  logic [ENABLE_WIDTH-1:0] enables_cfg;

  joint_position_limit_guard_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .position_a(position_a), .position_b(position_b),
    .position_c(position_c), .position_d(position_d), .nonfinite_mask(nonfinite_mask),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .passed_a(passed_a), .passed_b(passed_b), .passed_c(passed_c), .passed_d(passed_d),
    .below_mask(below_mask), .above_mask(above_mask), .jump_mask(jump_mask),
    .recovered(recovered)
  );

  jplg_checker guard_watch (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .position_a(position_a), .position_b(position_b),
    .position_c(position_c), .position_d(position_d), .nonfinite_mask(nonfinite_mask),
    .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
    .passed_a(passed_a), .passed_b(passed_b), .passed_c(passed_c), .passed_d(passed_d),
    .below_mask(below_mask), .above_mask(above_mask), .jump_mask(jump_mask),
    .recovered(recovered), .mismatches(mismatches), .outstanding(outstanding),
    .verdicts_seen(verdicts_seen), .stops_seen(stops_seen),
    .recoveries_seen(recoveries_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) in_taken <= in_valid && in_ready;

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none once calm.
  initial begin
    @(negedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        squeeze_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  task automatic send_vector(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                             input logic [15:0] d, input logic [MAX_AXES-1:0] m);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    position_a <= a;
    position_b <= b;
    position_c <= c;
    position_d <= d;
    nonfinite_mask <= m;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic program_guard();
    logic [CFG_WIDTH-1:0] lo_pack;
    logic [CFG_WIDTH-1:0] hi_pack;
    logic [CFG_WIDTH-1:0] step_pack;
    settle();
    for (int k = 0; k < MAX_AXES; k++) begin
      lo_pack[16*k +: 16] = 16'(lo_lane[k]);
      hi_pack[16*k +: 16] = 16'(hi_lane[k]);
      step_pack[16*k +: 16] = 16'(step_lane[k]);
    end
    cfg_we <= 1'b1;
    cfg_index <= REG_LOWER_BOUNDS;
    cfg_data <= lo_pack;
    @(negedge clk);
    cfg_index <= REG_UPPER_BOUNDS;
    cfg_data <= hi_pack;
    @(negedge clk);
    cfg_index <= REG_STEP_BOUNDS;
    cfg_data <= step_pack;
    @(negedge clk);
    cfg_index <= REG_CHECK_ENABLES;
    cfg_data <= CFG_WIDTH'(enables_cfg);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic fill(input int lo, input int hi, input int st, input logic [7:0] en);
    for (int k = 0; k < MAX_AXES; k++) begin
      lo_lane[k] = lo;
      hi_lane[k] = hi;
      step_lane[k] = st;
    end
    enables_cfg = en;
    program_guard();
  endtask

  task automatic random_setup();
    for (int k = 0; k < MAX_AXES; k++) begin
      lo_lane[k] = -int'($urandom_range(1, 20000));
      hi_lane[k] = int'($urandom_range(1, 20000));
      step_lane[k] = int'($urandom_range(0, 3000));
    end
    enables_cfg = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom());
    program_guard();
  endtask

  function automatic logic [15:0] near_lane(input int center, input int spread, input int lo,
                                            input int hi);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return 16'(v);
  endfunction

  // Mostly small moves inside the bounds, with faults and arbitrary vectors mixed in.
  task automatic run_random(input int count);
    logic [15:0] p [MAX_AXES];
    logic [MAX_AXES-1:0] m;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      m = '0;
      for (int k = 0; k < MAX_AXES; k++) begin
        if (r >= 8) p[k] = 16'($urandom());
        else p[k] = near_lane(anchor[k], step_lane[k] * 3 / 4 + 1, lo_lane[k], hi_lane[k]);
      end
      if (r == 7) m = 4'($urandom_range(1, 15));
      else if (r >= 8 && $urandom_range(0, 3) == 0) m = 4'($urandom());
      if (r < 7)
        for (int k = 0; k < MAX_AXES; k++) anchor[k] = int'($signed(p[k]));
      send_vector(p[0], p[1], p[2], p[3], m);
    end
  endtask

  initial begin
    for (int k = 0; k < MAX_AXES; k++) anchor[k] = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With reset registers nothing is checked except non-finite readings.
    send_vector(16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0);
    send_vector(-16'sd32768, 16'sd32767, -16'sd1, 16'sd1, 4'h0);

    fill(-1000, 1000, 500, 8'h0F);
    send_vector(16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0);
    fill(-1000, 1000, 500, 8'hFF);
    send_vector(16'sd100, -16'sd100, 16'sd400, -16'sd500, 4'h0);
    send_vector(-16'sd1200, 16'sd0, 16'sd0, 16'sd0, 4'h0);
    send_vector(16'sd0, 16'sd1500, 16'sd0, 16'sd0, 4'h0);
    send_vector(16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'b0100);
    send_vector(16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'h0);
    send_vector(16'sd0, 16'sd0, 16'sd700, 16'sd0, 4'h0);
    send_vector(16'sd0, 16'sd0, 16'sd0, 16'sd0, 4'hF);
    send_vector(-16'sd500, 16'sd500, -16'sd500, 16'sd500, 4'h0);
    send_vector(-16'sd1000, 16'sd1000, -16'sd1000, 16'sd1000, 4'h0);

    // Crossed bounds: below wins, otherwise anything over the upper bound is flagged.
    fill(100, -100, 65535, 8'h0F);
    send_vector(16'sd50, -16'sd200, 16'sd200, 16'sd100, 4'h0);

    fill(-32768, 32767, 65535, 8'hFF);
    send_vector(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 4'h0);
    send_vector(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 4'h0);
    fill(-32768, 32767, 65534, 8'hFF);
    send_vector(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 4'h0);
    send_vector(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 4'h0);
    fill(-32768, 32767, 0, 8'hFF);
    send_vector(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 4'h0);
    send_vector(16'sd32766, 16'sd32767, 16'sd32767, 16'sd32767, 4'h0);

    random_setup();
    run_random(215);
    fill(-32768, 32767, 65535, 8'hFF);
    run_random(215);
    random_setup();
    squeeze_req = 1'b1;
    run_random(215);
    fill(0, 0, 0, 8'hFF);
    run_random(215);
    random_setup();
    run_random(215);
    random_setup();
    calm = 1'b1;
    run_random(215);

    settle();
    repeat (4) @(negedge clk);
    $display("Checked %0d guard results: %0d emergency stops, %0d recoveries, %0d settings.",
             verdicts_seen, stops_seen, recoveries_seen, settings_used);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
